### rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, format codes and layout tables for the pixel format converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

  // format codes
  localparam logic [2:0] FMT_RGBA8  = 3'd0;
  localparam logic [2:0] FMT_RGBA4  = 3'd1;
  localparam logic [2:0] FMT_RGB5A1 = 3'd2;
  localparam logic [2:0] FMT_RGB8   = 3'd3;
  localparam logic [2:0] FMT_RGB565 = 3'd4;
  localparam logic [2:0] FMT_LA8    = 3'd5;
  localparam logic [2:0] FMT_L8     = 3'd6;
  localparam logic [2:0] FMT_NONE   = 3'd7;

  // configuration register indexes
  localparam logic REG_SOURCE = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  // channel indexes
  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;
  localparam logic [1:0] CH_A = 2'd3;

  localparam int PIX_W    = 32;
  localparam int FMT_W    = 3;
  localparam int CNT_W    = 3;
  localparam int LEVEL_W  = 18;
  localparam int SUM_W    = 19;
  localparam int NUM_W    = 27;
  localparam int CHAN_W   = 8;
  localparam int RECIP_W  = 29;
  localparam int RECIP_SH = 46;
  localparam int PROD_W   = NUM_W + RECIP_W;

  // common denominator of all channel maxima (lcm of 255, 63, 31, 15, 1)
  localparam logic [LEVEL_W-1:0] FULL_SCALE  = LEVEL_W'(166005);
  localparam logic [SUM_W-1:0]   FULL_SCALE3 = SUM_W'(3 * 166005);

  // ceiling reciprocals, exact floor division for numerators below 2^27
  localparam logic [63:0] RECIP_1_FULL =
    ((64'd1 << RECIP_SH) + 64'd166005 - 64'd1) / 64'd166005;
  localparam logic [63:0] RECIP_3_FULL =
    ((64'd1 << RECIP_SH) + 64'd498015 - 64'd1) / 64'd498015;
  localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_1_FULL[RECIP_W-1:0];
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_3_FULL[RECIP_W-1:0];

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [CHAN_W-1:0]  chan_t;

  // bit offset of a channel in a format
  function automatic logic [4:0] fmt_shift(logic [2:0] fmt, logic [1:0] ch);
    logic [4:0] s;
    s = 5'd0;
    case (fmt)
      FMT_RGBA4: begin
        case (ch)
          CH_R: s = 5'd12;
          CH_G: s = 5'd8;
          CH_B: s = 5'd4;
          default: s = 5'd0;
        endcase
      end
      FMT_RGB5A1: begin
        case (ch)
          CH_R: s = 5'd11;
          CH_G: s = 5'd6;
          CH_B: s = 5'd1;
          default: s = 5'd0;
        endcase
      end
      FMT_RGB8: begin
        case (ch)
          CH_G: s = 5'd8;
          CH_B: s = 5'd16;
          default: s = 5'd0;
        endcase
      end
      FMT_RGB565: begin
        case (ch)
          CH_R: s = 5'd11;
          CH_G: s = 5'd5;
          default: s = 5'd0;
        endcase
      end
      FMT_LA8: begin
        case (ch)
          CH_A: s = 5'd8;
          default: s = 5'd0;
        endcase
      end
      FMT_L8: s = 5'd0;
      default: begin
        case (ch)
          CH_G: s = 5'd8;
          CH_B: s = 5'd16;
          CH_A: s = 5'd24;
          default: s = 5'd0;
        endcase
      end
    endcase
    return s;
  endfunction

  // bit width of a channel in a format, zero when absent
  function automatic logic [3:0] fmt_width(logic [2:0] fmt, logic [1:0] ch);
    logic [3:0] w;
    w = 4'd0;
    case (fmt)
      FMT_RGBA4:  w = 4'd4;
      FMT_RGB5A1: w = (ch == CH_A) ? 4'd1 : 4'd5;
      FMT_RGB8:   w = (ch == CH_A) ? 4'd0 : 4'd8;
      FMT_RGB565: begin
        case (ch)
          CH_R: w = 4'd5;
          CH_G: w = 4'd6;
          CH_B: w = 4'd5;
          default: w = 4'd0;
        endcase
      end
      FMT_LA8:    w = (ch == CH_R || ch == CH_A) ? 4'd8 : 4'd0;
      FMT_L8:     w = (ch == CH_R) ? 4'd8 : 4'd0;
      default:    w = 4'd8;
    endcase
    return w;
  endfunction

  // byte size of a format
  function automatic logic [CNT_W-1:0] fmt_bytes(logic [2:0] fmt);
    logic [CNT_W-1:0] b;
    case (fmt)
      FMT_RGBA4, FMT_RGB5A1, FMT_RGB565, FMT_LA8: b = 3'd2;
      FMT_RGB8: b = 3'd3;
      FMT_L8:   b = 3'd1;
      default:  b = 3'd4;
    endcase
    return b;
  endfunction

  // luminance formats
  function automatic logic fmt_lum(logic [2:0] fmt);
    return (fmt == FMT_LA8) || (fmt == FMT_L8);
  endfunction

  // largest code of a channel of the given width
  function automatic chan_t width_max(logic [3:0] w);
    chan_t m;
    case (w)
      4'd1:    m = 8'd1;
      4'd4:    m = 8'd15;
      4'd5:    m = 8'd31;
      4'd6:    m = 8'd63;
      4'd8:    m = 8'd255;
      default: m = 8'd0;
    endcase
    return m;
  endfunction

  // full scale divided by the channel maximum
  function automatic level_t width_scale(logic [3:0] w);
    level_t k;
    case (w)
      4'd1:    k = LEVEL_W'(166005);
      4'd4:    k = LEVEL_W'(11067);
      4'd5:    k = LEVEL_W'(5355);
      4'd6:    k = LEVEL_W'(2635);
      4'd8:    k = LEVEL_W'(651);
      default: k = LEVEL_W'(0);
    endcase
    return k;
  endfunction

endpackage

### rtl/pfc_in_if.sv
// ----------------------------------------------------------------------------
// pfc_in_if
// Source pixel channel: valid/ready handshake with pixel and end-of-image mark.
// ----------------------------------------------------------------------------
interface pfc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_in;
  logic        last_in;

  modport source (output valid, output pixel_in, output last_in, input ready);
  modport sink   (input valid, input pixel_in, input last_in, output ready);
endinterface

### rtl/pfc_out_if.sv
// ----------------------------------------------------------------------------
// pfc_out_if
// Converted pixel channel: valid/ready handshake with pixel, size and mark.
// ----------------------------------------------------------------------------
interface pfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic [2:0]  pixel_size;
  logic        last_out;

  modport source (output valid, output pixel_out, output pixel_size, output last_out,
                  input ready);
  modport sink   (input valid, input pixel_out, input pixel_size, input last_out,
                  output ready);
endinterface

### rtl/pixel_format_converter.sv
// ----------------------------------------------------------------------------
// pixel_format_converter
// Converts one packed little-endian pixel per transfer between seven formats.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in  carries one source pixel per transfer (valid/ready), with last_in
//           marking the final pixel of an image; pix_out returns the
//           converted pixel, its byte count and the copied mark.
//   cfg_write/cfg_index/cfg_data set the source (index 0) and target
//   (index 1) formats; a value of 7 is ignored. Write only while idle.
//   Results are presented from the output register. Throughput is one
//   pixel per cycle while the receiver accepts: four register stages
//   (unpack and scale to a common level, multiply by the output maximum,
//   reciprocal multiply, pack) each take a new pixel every cycle unless stalled.
//   When the receiver stalls, the output register holds its pixel and
//   earlier stages keep filling bubbles; ready drops only once every stage
//   holds a pixel. Nothing is dropped or repeated.
//   Reset clears all stage valid bits and sets both formats to RGBA8.
// ----------------------------------------------------------------------------
module pixel_format_converter (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [pfc_pkg::FMT_W-1:0] cfg_data,
  pfc_in_if.sink                 pix_in,
  pfc_out_if.source              pix_out
);
  import pfc_pkg::*;

  logic [FMT_W-1:0] source_format;
  logic [FMT_W-1:0] target_format;

  // stage valids and advance enables
  logic v1, v2, v3, vo;
  logic adv0, adv1, adv2, adv3;

  // stage 1: levels over full scale
  level_t           s1_level [4];
  logic [FMT_W-1:0] s1_tfmt;
  logic             s1_last;

  // stage 2: numerators times output maximum
  num_t             s2_num [4];
  logic             s2_lum;
  logic [FMT_W-1:0] s2_tfmt;
  logic             s2_last;

  // stage 3: output channel codes
  chan_t            s3_q [4];
  logic [FMT_W-1:0] s3_tfmt;
  logic             s3_last;

  // output register
  logic [PIX_W-1:0] out_pixel;
  logic [CNT_W-1:0] out_count;
  logic             out_last;

  level_t           level_next [4];
  num_t             num_next [4];
  chan_t            q_next [4];
  logic [PIX_W-1:0] pixel_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_RGBA8;
      target_format <= FMT_RGBA8;
    end else if (cfg_write && cfg_data != FMT_NONE) begin
      case (cfg_index)
        REG_SOURCE: source_format <= cfg_data;
        REG_TARGET: target_format <= cfg_data;
        default: ;
      endcase
    end
  end

  // backpressure chain, bubbles collapse
  assign adv3 = !vo || pix_out.ready;
  assign adv2 = !v3 || adv3;
  assign adv1 = !v2 || adv2;
  assign adv0 = !v1 || adv1;
  assign pix_in.ready = adv0;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (adv0) v1 <= pix_in.valid;
      if (adv1) v2 <= v1;
      if (adv2) v3 <= v2;
      if (adv3) vo <= v3;
    end
  end

  // unpack source channels and scale to a common level
  always_comb begin
    logic [3:0]  w;
    logic [7:0]  v;
    logic [25:0] p;
    for (int c = 0; c < 4; c++) begin
      w = fmt_width(source_format, 2'(c));
      v = 8'(pix_in.pixel_in >> fmt_shift(source_format, 2'(c))) & width_max(w);
      p = v * width_scale(w);
      if (w != 4'd0) begin
        level_next[c] = p[LEVEL_W-1:0];
      end else begin
        level_next[c] = (2'(c) == CH_A) ? FULL_SCALE : '0;
      end
    end
    if (fmt_lum(source_format)) begin
      level_next[CH_G] = level_next[CH_R];
      level_next[CH_B] = level_next[CH_R];
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      for (int c = 0; c < 4; c++) s1_level[c] <= level_next[c];
      s1_tfmt <= target_format;
      s1_last <= pix_in.last_in;
    end
  end

  // numerator per output channel times its maximum
  always_comb begin
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] n;
    sum = SUM_W'(s1_level[CH_R]) + SUM_W'(s1_level[CH_G]) + SUM_W'(s1_level[CH_B]);
    for (int c = 0; c < 4; c++) begin
      if (2'(c) == CH_R && fmt_lum(s1_tfmt)) n = sum;
      else                                    n = SUM_W'(s1_level[c]);
      num_next[c] = NUM_W'(n) * NUM_W'(width_max(fmt_width(s1_tfmt, 2'(c))));
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int c = 0; c < 4; c++) s2_num[c] <= num_next[c];
      s2_lum  <= fmt_lum(s1_tfmt);
      s2_tfmt <= s1_tfmt;
      s2_last <= s1_last;
    end
  end

  // floor division by full scale (three times it for a luminance sum) via reciprocal multiply
  always_comb begin
    logic [PROD_W-1:0] prod;
    logic [RECIP_W-1:0] recip;
    for (int c = 0; c < 4; c++) begin
      recip = (2'(c) == CH_R && s2_lum) ? RECIP_3 : RECIP_1;
      prod = PROD_W'(s2_num[c]) * PROD_W'(recip);
      q_next[c] = prod[RECIP_SH +: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      for (int c = 0; c < 4; c++) s3_q[c] <= q_next[c];
      s3_tfmt <= s2_tfmt;
      s3_last <= s2_last;
    end
  end

  // pack channels in target layout
  always_comb begin
    pixel_next = '0;
    for (int c = 0; c < 4; c++) begin
      pixel_next = pixel_next |
        (PIX_W'(s3_q[c] & width_max(fmt_width(s3_tfmt, 2'(c))))
          << fmt_shift(s3_tfmt, 2'(c)));
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      out_pixel <= pixel_next;
      out_count <= fmt_bytes(s3_tfmt);
      out_last  <= s3_last;
    end
  end

  assign pix_out.valid      = vo;
  assign pix_out.pixel_out  = out_pixel;
  assign pix_out.pixel_size = out_count;
  assign pix_out.last_out   = out_last;

  // checks
  a_fmt_legal: assert property (@(posedge clk) disable iff (rst)
    source_format != FMT_NONE && target_format != FMT_NONE)
    else $error("format register holds unused code");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    vo |-> (out_count == 3'd1 || out_count == 3'd2 || out_count == 3'd3 ||
            out_count == 3'd4))
    else $error("byte count out of range");

  a_high_zero: assert property (@(posedge clk) disable iff (rst)
    vo |-> ((out_count != 3'd1 || out_pixel[31:8] == 24'd0) &&
            (out_count != 3'd2 || out_pixel[31:16] == 16'd0) &&
            (out_count != 3'd3 || out_pixel[31:24] == 8'd0)))
    else $error("unused output bytes not zero");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !adv3) |=> v3)
    else $error("stalled stage lost its pixel");

endmodule
